FILE: hw/rtl/lic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types, codes and the control-store program of the index unravel unit.
// ----------------------------------------------------------------------------
package lic_pkg;

	localparam int MAX_RANK_DEF    = 6;
	localparam int EXTENT_BITS_DEF = 16;
	localparam int NUM_EXTENTS     = 6;
	localparam int INDEX_BITS      = 64;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int COORD_BITS      = 16;
	localparam int USTEP_BITS      = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_RANK     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXTENT_0 = 3'd1;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
	localparam logic [1:0] STATUS_SCALAR   = 2'd3;

	typedef struct packed {
		logic signed [INDEX_BITS-1:0] linear_index;
	} lic_index_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] coordinate;
		logic [2:0]            dimension;
		logic [1:0]            status;
		logic                  last;
	} lic_coord_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_MUL_ACC,
		OP_EMIT_OVF,
		OP_EMIT_OOR,
		OP_EMIT_SCALAR,
		OP_SET_DIM,
		OP_DIV_START,
		OP_DIV_WAIT,
		OP_EMIT_COORD,
		OP_DEC_DIM
	} lic_op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_CNT_DONE,
		COND_NO_OVF,
		COND_IN_RANGE,
		COND_RANK_NZ,
		COND_LAST
	} lic_cond_t;

	typedef struct packed {
		lic_op_t                op;
		lic_cond_t              cond;
		logic [USTEP_BITS-1:0]  target;
	} lic_uword_t;

	// control-store addresses
	localparam logic [USTEP_BITS-1:0] UA_ACCEPT      = 4'd0;
	localparam logic [USTEP_BITS-1:0] UA_CNT_CHK     = 4'd1;
	localparam logic [USTEP_BITS-1:0] UA_MUL_LO      = 4'd2;
	localparam logic [USTEP_BITS-1:0] UA_MUL_HI      = 4'd3;
	localparam logic [USTEP_BITS-1:0] UA_MUL_ACC     = 4'd4;
	localparam logic [USTEP_BITS-1:0] UA_OVF_CHK     = 4'd5;
	localparam logic [USTEP_BITS-1:0] UA_EMIT_OVF    = 4'd6;
	localparam logic [USTEP_BITS-1:0] UA_RANGE_CHK   = 4'd7;
	localparam logic [USTEP_BITS-1:0] UA_EMIT_OOR    = 4'd8;
	localparam logic [USTEP_BITS-1:0] UA_RANK_CHK    = 4'd9;
	localparam logic [USTEP_BITS-1:0] UA_EMIT_SCALAR = 4'd10;
	localparam logic [USTEP_BITS-1:0] UA_SET_DIM     = 4'd11;
	localparam logic [USTEP_BITS-1:0] UA_DIV_START   = 4'd12;
	localparam logic [USTEP_BITS-1:0] UA_DIV_WAIT    = 4'd13;
	localparam logic [USTEP_BITS-1:0] UA_EMIT_COORD  = 4'd14;
	localparam logic [USTEP_BITS-1:0] UA_DEC_DIM     = 4'd15;

	// control store: count loop, status checks, then the divide loop
	function automatic lic_uword_t lic_ucode(input logic [USTEP_BITS-1:0] step);
		lic_uword_t w;
		unique case (step)
			UA_ACCEPT:      w = '{OP_ACCEPT,      COND_NEXT,     UA_ACCEPT};
			UA_CNT_CHK:     w = '{OP_NOP,         COND_CNT_DONE, UA_OVF_CHK};
			UA_MUL_LO:      w = '{OP_MUL_LO,      COND_NEXT,     UA_ACCEPT};
			UA_MUL_HI:      w = '{OP_MUL_HI,      COND_NEXT,     UA_ACCEPT};
			UA_MUL_ACC:     w = '{OP_MUL_ACC,     COND_ALWAYS,   UA_CNT_CHK};
			UA_OVF_CHK:     w = '{OP_NOP,         COND_NO_OVF,   UA_RANGE_CHK};
			UA_EMIT_OVF:    w = '{OP_EMIT_OVF,    COND_ALWAYS,   UA_ACCEPT};
			UA_RANGE_CHK:   w = '{OP_NOP,         COND_IN_RANGE, UA_RANK_CHK};
			UA_EMIT_OOR:    w = '{OP_EMIT_OOR,    COND_ALWAYS,   UA_ACCEPT};
			UA_RANK_CHK:    w = '{OP_NOP,         COND_RANK_NZ,  UA_SET_DIM};
			UA_EMIT_SCALAR: w = '{OP_EMIT_SCALAR, COND_ALWAYS,   UA_ACCEPT};
			UA_SET_DIM:     w = '{OP_SET_DIM,     COND_NEXT,     UA_ACCEPT};
			UA_DIV_START:   w = '{OP_DIV_START,   COND_NEXT,     UA_ACCEPT};
			UA_DIV_WAIT:    w = '{OP_DIV_WAIT,    COND_NEXT,     UA_ACCEPT};
			UA_EMIT_COORD:  w = '{OP_EMIT_COORD,  COND_LAST,     UA_ACCEPT};
			UA_DEC_DIM:     w = '{OP_DEC_DIM,     COND_ALWAYS,   UA_DIV_START};
			default:        w = '{OP_NOP,         COND_ALWAYS,   UA_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/lic_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lic_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/lic_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_divider
// Radix-2 restoring divider: 64-bit dividend by an extent, one bit per cycle.
// ----------------------------------------------------------------------------
module lic_divider #(
	parameter int DIVISOR_BITS = lic_pkg::EXTENT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [lic_pkg::INDEX_BITS-1:0]     dividend,
	input  logic [DIVISOR_BITS-1:0]            divisor,
	output logic                               busy,
	output logic [lic_pkg::INDEX_BITS-1:0]     quotient,
	output logic [DIVISOR_BITS-1:0]            remainder
);
	localparam int DividendW = lic_pkg::INDEX_BITS;
	localparam int CntW      = $clog2(DividendW + 1);

	logic                  busy_q;
	logic [CntW-1:0]       cnt_q;
	logic [DividendW-1:0]  quo_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] dvsr_q;

	logic [DIVISOR_BITS:0] trial;
	logic [DIVISOR_BITS:0] diff;
	logic                  ge;

	always_comb begin
		trial = {rem_q, quo_q[DividendW-1]};
		diff  = trial - {1'b0, dvsr_q};
		ge    = (trial >= {1'b0, dvsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(DividendW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DividendW-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/lic_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lic_seq
// Control-store sequencer and datapath: element count, checks, divide loop.
// ----------------------------------------------------------------------------
module lic_seq #(
	parameter int EXTENT_BITS = lic_pkg::EXTENT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [2:0]             rank,
	input  logic [EXTENT_BITS-1:0] extents [lic_pkg::NUM_EXTENTS],
	lic_stream_if.sink             idx,
	lic_stream_if.source           coord
);
	localparam int IdxW  = lic_pkg::INDEX_BITS;
	localparam int HalfW = IdxW / 2;
	localparam int ProdW = HalfW + EXTENT_BITS;
	localparam int FullW = IdxW + EXTENT_BITS + 1;
	localparam int KeepW = (EXTENT_BITS < lic_pkg::COORD_BITS) ? EXTENT_BITS
	                                                           : lic_pkg::COORD_BITS;

	logic [lic_pkg::USTEP_BITS-1:0] step_q;
	logic [IdxW-1:0]                idx_q;
	logic [IdxW-1:0]                acc_q;
	logic [IdxW-1:0]                q_q;
	logic                           ovf_q;
	logic [2:0]                     cnt_q;
	logic [ProdW-1:0]               plo_q;
	logic [ProdW-1:0]               phi_q;
	logic                           out_valid_q;
	lic_pkg::lic_coord_t            out_q;

	lic_pkg::lic_uword_t            uw;
	logic [EXTENT_BITS-1:0]         ext_sel;
	logic [FullW-1:0]               full;
	logic                           mul_ovf;
	logic                           out_free;
	logic                           is_emit;
	logic                           stall;
	logic                           fire;
	logic                           taken;
	logic                           div_start;
	logic                           div_busy;
	logic [IdxW-1:0]                div_quo;
	logic [EXTENT_BITS-1:0]         div_rem;
	lic_pkg::lic_coord_t            emit_data;

	lic_divider #(
		.DIVISOR_BITS(EXTENT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_q),
		.divisor  (ext_sel),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		uw      = lic_pkg::lic_ucode(step_q);
		ext_sel = (cnt_q < 3'(lic_pkg::NUM_EXTENTS)) ? extents[cnt_q] : '0;
		full    = (FullW'(phi_q) << HalfW) + FullW'(plo_q);
		mul_ovf = |full[FullW-1:IdxW-1];

		out_free = !out_valid_q || coord.ready;
		is_emit  = (uw.op == lic_pkg::OP_EMIT_OVF) || (uw.op == lic_pkg::OP_EMIT_OOR) ||
		           (uw.op == lic_pkg::OP_EMIT_SCALAR) || (uw.op == lic_pkg::OP_EMIT_COORD);
		// hold the step while waiting on input, output slot or divider
		stall = ((uw.op == lic_pkg::OP_ACCEPT) && !idx.valid) ||
		        (is_emit && !out_free) ||
		        ((uw.op == lic_pkg::OP_DIV_WAIT) && div_busy);
		fire  = !stall;

		unique case (uw.cond)
			lic_pkg::COND_NEXT:     taken = 1'b0;
			lic_pkg::COND_ALWAYS:   taken = 1'b1;
			lic_pkg::COND_CNT_DONE: taken = ovf_q || (cnt_q == rank);
			lic_pkg::COND_NO_OVF:   taken = !ovf_q;
			lic_pkg::COND_IN_RANGE: taken = !idx_q[IdxW-1] && (idx_q < acc_q);
			lic_pkg::COND_RANK_NZ:  taken = (rank != 3'd0);
			lic_pkg::COND_LAST:     taken = (cnt_q == 3'd0);
			default:                taken = 1'b1;
		endcase

		div_start = fire && (uw.op == lic_pkg::OP_DIV_START);

		emit_data = '0;
		unique case (uw.op)
			lic_pkg::OP_EMIT_OVF: begin
				emit_data.status = lic_pkg::STATUS_OVERFLOW;
				emit_data.last   = 1'b1;
			end
			lic_pkg::OP_EMIT_OOR: begin
				emit_data.status = lic_pkg::STATUS_RANGE;
				emit_data.last   = 1'b1;
			end
			lic_pkg::OP_EMIT_SCALAR: begin
				emit_data.status = lic_pkg::STATUS_SCALAR;
				emit_data.last   = 1'b1;
			end
			lic_pkg::OP_EMIT_COORD: begin
				emit_data.coordinate = lic_pkg::COORD_BITS'(div_rem[KeepW-1:0]);
				emit_data.dimension  = cnt_q;
				emit_data.status     = lic_pkg::STATUS_OK;
				emit_data.last       = (cnt_q == 3'd0);
			end
			default: emit_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lic_pkg::UA_ACCEPT;
			acc_q       <= IdxW'(1);
			q_q         <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && is_emit) begin
				out_valid_q <= 1'b1;
			end else if (coord.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				step_q <= taken ? uw.target : step_q + lic_pkg::USTEP_BITS'(1);
				unique case (uw.op)
					lic_pkg::OP_ACCEPT: begin
						acc_q <= IdxW'(1);
						ovf_q <= 1'b0;
						cnt_q <= '0;
					end
					lic_pkg::OP_MUL_ACC: begin
						if (mul_ovf) begin
							ovf_q <= 1'b1;
						end else begin
							acc_q <= full[IdxW-1:0];
							cnt_q <= cnt_q + 3'd1;
						end
					end
					lic_pkg::OP_SET_DIM: begin
						q_q   <= idx_q;
						cnt_q <= rank - 3'd1;
					end
					lic_pkg::OP_DIV_WAIT: q_q <= div_quo;
					lic_pkg::OP_DEC_DIM:  cnt_q <= cnt_q - 3'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (uw.op == lic_pkg::OP_ACCEPT)) begin
			idx_q <= idx.data.linear_index;
		end
		if (fire && (uw.op == lic_pkg::OP_MUL_LO)) begin
			plo_q <= ProdW'(acc_q[HalfW-1:0]) * ProdW'(ext_sel);
		end
		if (fire && (uw.op == lic_pkg::OP_MUL_HI)) begin
			phi_q <= ProdW'(acc_q[IdxW-1:HalfW]) * ProdW'(ext_sel);
		end
		if (fire && is_emit) begin
			out_q <= emit_data;
		end
	end

	assign idx.ready   = (uw.op == lic_pkg::OP_ACCEPT);
	assign coord.valid = out_valid_q;
	assign coord.data  = out_q;

`ifndef SYNTHESIS
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		coord.valid && (coord.data.status != lic_pkg::STATUS_OK) |->
		coord.data.last && (coord.data.coordinate == '0) && (coord.data.dimension == 3'd0))
		else $error("status result not a single zeroed item");

	a_last_is_dim0: assert property (@(posedge clk) disable iff (!arst_n)
		coord.valid && (coord.data.status == lic_pkg::STATUS_OK) |->
		(coord.data.last == (coord.data.dimension == 3'd0)))
		else $error("last flag disagrees with dimension");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !idx.ready)
		else $error("input ready while dividing");
`endif

endmodule

FILE: hw/rtl/linear_index_to_coordinates_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_index_to_coordinates_top
// Unravels a signed linear index into row-major coordinates of a set shape.
// ----------------------------------------------------------------------------
// A status result follows the count loop and checks. For a valid index, each
// dimension passes the count multiply (low half, high half, accumulate), the
// bit-per-cycle divider, and steps to start, emit and step down. One item is
// worked on at a time.
// Reset clears the sequencer and sets rank 0 and every extent to 1.
module linear_index_to_coordinates_top #(
	parameter int MAX_RANK    = lic_pkg::MAX_RANK_DEF,
	parameter int EXTENT_BITS = lic_pkg::EXTENT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lic_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [lic_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	lic_stream_if.sink                         idx,
	lic_stream_if.source                       coord
);
	localparam int KeptW = (EXTENT_BITS < lic_pkg::CFG_DATA_BITS) ? EXTENT_BITS
	                                                              : lic_pkg::CFG_DATA_BITS;

	logic [2:0]             rank_q;
	logic [EXTENT_BITS-1:0] ext_q [lic_pkg::NUM_EXTENTS];
	logic [2:0]             used_rank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= 3'd0;
			for (int i = 0; i < lic_pkg::NUM_EXTENTS; i++) begin
				ext_q[i] <= EXTENT_BITS'(1);
			end
		end else if (cfg_we) begin
			if (cfg_idx == lic_pkg::CFG_RANK) begin
				rank_q <= cfg_wdata[2:0];
			end
			for (int i = 0; i < lic_pkg::NUM_EXTENTS; i++) begin
				if (cfg_idx == lic_pkg::CFG_EXTENT_0 + 3'(i)) begin
					ext_q[i] <= EXTENT_BITS'(cfg_wdata[KeptW-1:0]);
				end
			end
		end
	end

	// clamp rank to the supported maximum
	assign used_rank = (rank_q > 3'(MAX_RANK)) ? 3'(MAX_RANK) : rank_q;

	lic_seq #(
		.EXTENT_BITS(EXTENT_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.rank   (used_rank),
		.extents(ext_q),
		.idx    (idx),
		.coord  (coord)
	);

endmodule
